// ===== rtl/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

  localparam int MAX_OUTPUT = 4096;
  localparam int CNT_W      = 13;
  localparam int LEN_W      = 13;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OUTPUT);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX0   = 2'd2,
    MODE_HEX1   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             done;
    logic             valid;
    logic [7:0]       data;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } job_t;

  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      CH_N:    v = CH_LF;
      CH_T:    v = CH_TAB;
      CH_R:    v = CH_CR;
      default: v = b;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/esd_front.sv =====
`default_nettype none

module esd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          q_full,
  output logic               q_push,
  output esd_pkg::job_t      q_wdata
);
  import esd_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [3:0]       held_r, held_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             accept;
  logic             is_hex;
  logic [3:0]       hval;
  logic             full;
  logic [CNT_W-1:0] cnt1, cnt2;
  logic             any;
  job_t             job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign full      = cnt_r >= MAX_CNT;
  assign cnt1      = cnt_r + CNT_W'(1);
  assign cnt2      = cnt_r + CNT_W'(2);

  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (in_tdata >= 8'h30 && in_tdata <= 8'h39) begin
      hval = 4'(in_tdata - 8'h30);
    end else if (in_tdata >= 8'h41 && in_tdata <= 8'h46) begin
      hval = 4'(in_tdata - 8'h37);
    end else if (in_tdata >= 8'h61 && in_tdata <= 8'h66) begin
      hval = 4'(in_tdata - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (in_tdata == CH_NUL) begin
      mode_nxt = MODE_NORMAL;
      held_nxt = 4'd0;
      cnt_nxt  = '0;
    end else if (full) begin
      mode_nxt = MODE_NORMAL;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          if (in_tdata == CH_X) begin
            mode_nxt = MODE_HEX0;
          end else begin
            mode_nxt = MODE_NORMAL;
            cnt_nxt  = cnt1;
          end
        end
        MODE_HEX0: begin
          if (is_hex) begin
            held_nxt = hval;
            mode_nxt = MODE_HEX1;
          end else if (in_tdata == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_NORMAL;
            cnt_nxt  = cnt1;
          end
        end
        MODE_HEX1: begin
          held_nxt = 4'd0;
          mode_nxt = MODE_NORMAL;
          cnt_nxt  = cnt1;
          if (!is_hex && cnt1 < MAX_CNT) begin
            if (in_tdata == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end else begin
              cnt_nxt = cnt2;
            end
          end
        end
        default: begin
          if (in_tdata == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else begin
            cnt_nxt = cnt1;
          end
        end
      endcase
    end
  end

  // result beats for this byte
  always_comb begin
    any = 1'b0;
    job = '0;
    if (in_tdata == CH_NUL) begin
      any = 1'b1;
      if (mode_r == MODE_HEX1 && !full) begin
        job.two      = 1'b1;
        job.r0.data  = {4'd0, held_r};
        job.r0.valid = 1'b1;
        job.r0.len   = cnt1;
        job.r1.done  = 1'b1;
        job.r1.len   = cnt1;
      end else begin
        job.r0.done = 1'b1;
        job.r0.len  = cnt_r;
      end
    end else if (!full) begin
      job.r0.valid = 1'b1;
      job.r0.len   = cnt1;
      case (mode_r)
        MODE_ESC: begin
          any         = in_tdata != CH_X;
          job.r0.data = esc_map(in_tdata);
        end
        MODE_HEX0: begin
          any         = !is_hex && in_tdata != CH_BSL;
          job.r0.data = in_tdata;
        end
        MODE_HEX1: begin
          any = 1'b1;
          if (is_hex) begin
            job.r0.data = {held_r, hval};
          end else begin
            job.r0.data = {4'd0, held_r};
            if (cnt1 < MAX_CNT && in_tdata != CH_BSL) begin
              job.two      = 1'b1;
              job.r1.data  = in_tdata;
              job.r1.valid = 1'b1;
              job.r1.len   = cnt2;
            end
          end
        end
        default: begin
          any         = in_tdata != CH_BSL;
          job.r0.data = in_tdata;
        end
      endcase
    end
  end

  assign q_push  = accept && any;
  assign q_wdata = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      held_r <= 4'd0;
      cnt_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("emitted count above limit");
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tdata == CH_NUL |=> cnt_r == '0 && mode_r == MODE_NORMAL)
    else $error("terminator did not clear state");
`endif

endmodule

`default_nettype wire

// ===== rtl/esd_queue.sv =====
`default_nettype none

module esd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire esd_pkg::job_t  wdata,
  output logic                full,
  input  wire logic           pop,
  output esd_pkg::job_t       rdata,
  output logic                empty
);
  import esd_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QAW:0]     cnt_r;

  assign full  = cnt_r == (QAW+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QAW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/esd_back.sv =====
`default_nettype none

module esd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire esd_pkg::job_t  q_rdata,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [23:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import esd_pkg::*;

  logic  sel_r, sel_nxt;
  logic  vld_r, vld_nxt;
  res_t  res_r, res_nxt;
  logic  last_r, last_nxt;
  logic  load;
  logic  cur_last;

  assign load     = !q_empty && (!vld_r || out_tready);
  assign cur_last = sel_r || !q_rdata.two;
  assign q_pop    = load && cur_last;

  always_comb begin
    sel_nxt  = sel_r;
    vld_nxt  = vld_r;
    res_nxt  = res_r;
    last_nxt = last_r;
    if (load) begin
      vld_nxt  = 1'b1;
      res_nxt  = sel_r ? q_rdata.r1 : q_rdata.r0;
      last_nxt = cur_last;
      sel_nxt  = !cur_last;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'd0, res_r.len, res_r.data};
  assign out_tuser  = {res_r.done, res_r.valid};
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && res_r.done |-> last_r && !res_r.valid)
    else $error("done beat not last or carries a byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_decoder.sv =====
`default_nettype none

// channel | dir | tdata                                | tuser                  | tlast
// in_     | in  | [7:0] in_byte                        | -                      | -
// out_    | out | [7:0] out_byte, [20:8] out_length    | [0] byte_valid, [1] done| run_last
//
// one source byte accepted per cycle while the result queue has room
// a source byte yields zero, one or two result beats, sent one per cycle while out_tready is high
// each result beat is registered in the job queue and then in the output register
// four-entry job queue decouples input stalls from output stalls
// synchronous active-low reset clears decode mode, count and queue

module escape_sequence_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [20:8] out_length
  output logic [1:0]       out_tuser,  // [0] byte_valid, [1] string_done
  output logic             out_tlast
);
  import esd_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  job_t q_wdata, q_rdata;

  esd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  esd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  esd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;
  import esd_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 1750;
  localparam int MAX_SHOWN  = 30;

  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             done;
    logic [LEN_W-1:0] len;
    logic             last;
  } dec_beat_t;

  typedef enum logic [2:0] {
    ESC_LF, ESC_TAB, ESC_CR, ESC_BSL, ESC_OTHER, ESC_HEX0, ESC_HEX1, ESC_HEX2
  } esc_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] out_byte, [20:8] out_length
  logic [1:0]  out_tuser;          // [0] byte_valid, [1] string_done
  logic        out_tlast;

  escape_sequence_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  logic [7:0] src_q [$];
  dec_beat_t  decoded_q [$];

  // decoder shadow state
  mode_t      dec_mode = MODE_NORMAL;
  logic [3:0] held_hi = 4'h0;
  int         out_count = 0;
  dec_beat_t  step_res [2];
  int         step_n;

  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_strings = 0;
  int n_holds = 0;

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    return -1;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    if (out_count >= MAX_OUTPUT) return;
    out_count++;
    step_res[step_n] = '{data: b, valid: 1'b1, done: 1'b0,
                         len: LEN_W'(out_count), last: 1'b0};
    step_n++;
  endtask

  task automatic plain_byte(input logic [7:0] b);
    if (out_count >= MAX_OUTPUT) return;
    if (b == CH_BSL) dec_mode = MODE_ESC;
    else add_byte(b);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int h;
    h = hex_digit(b);
    step_n = 0;
    if (b == CH_NUL) begin
      if (dec_mode == MODE_HEX1) add_byte({4'h0, held_hi});
      step_res[step_n] = '{data: 8'h00, valid: 1'b0, done: 1'b1,
                           len: LEN_W'(out_count), last: 1'b0};
      step_n++;
      dec_mode = MODE_NORMAL;
      held_hi = 4'h0;
      out_count = 0;
    end else if (out_count >= MAX_OUTPUT) begin
      dec_mode = MODE_NORMAL;
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          dec_mode = MODE_NORMAL;
          if (b == CH_N) add_byte(CH_LF);
          else if (b == CH_T) add_byte(CH_TAB);
          else if (b == CH_R) add_byte(CH_CR);
          else if (b == CH_X) dec_mode = MODE_HEX0;
          else add_byte(b);
        end
        MODE_HEX0: begin
          if (h >= 0) begin
            held_hi = h[3:0];
            dec_mode = MODE_HEX1;
          end else begin
            dec_mode = MODE_NORMAL;
            plain_byte(b);
          end
        end
        MODE_HEX1: begin
          dec_mode = MODE_NORMAL;
          if (h >= 0) begin
            add_byte({held_hi, h[3:0]});
          end else begin
            add_byte({4'h0, held_hi});
            plain_byte(b);
          end
          held_hi = 4'h0;
        end
        default: begin
          dec_mode = MODE_NORMAL;
          plain_byte(b);
        end
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
  endtask

  task automatic report_mismatch(input string msg);
    if (n_err < MAX_SHOWN) $display("mismatch: %s", msg);
    n_err++;
  endtask

  task automatic check_beat();
    dec_beat_t e;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat tdata %h tuser %b tlast %b",
                                out_tdata, out_tuser, out_tlast));
      return;
    end
    e = decoded_q.pop_front();
    if (out_tdata[7:0] !== e.data)
      report_mismatch($sformatf("beat %0d out_byte %h, want %h", n_out, out_tdata[7:0], e.data));
    if (out_tuser[0] !== e.valid)
      report_mismatch($sformatf("beat %0d byte_valid %b, want %b", n_out, out_tuser[0], e.valid));
    if (out_tuser[1] !== e.done)
      report_mismatch($sformatf("beat %0d string_done %b, want %b", n_out, out_tuser[1], e.done));
    if (out_tdata[20:8] !== e.len)
      report_mismatch($sformatf("beat %0d out_length %0d, want %0d", n_out, out_tdata[20:8],
                                e.len));
    if (out_tlast !== e.last)
      report_mismatch($sformatf("beat %0d run_last %b, want %b", n_out, out_tlast, e.last));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // source side
  int in_gap = 0;
  int in_steady = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (src_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= src_q.pop_front();
          if (in_steady > 0) begin
            in_steady--;
            in_gap = 0;
          end else begin
            if ($urandom_range(0, 49) == 0) in_steady = $urandom_range(20, 80);
            in_gap = pick_gap();
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the stream is under way
  int  hold_left = 0;
  int  seen_in = 0;
  logic hold_armed = 1'b1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) seen_in <= seen_in + 1;
      if (hold_armed && seen_in >= HOLD_AFTER) begin
        hold_left <= HOLD_LEN;
        hold_armed <= 1'b0;
        n_holds <= n_holds + 1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // result side
  int out_gap = 0;
  int out_steady = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_beat();
        n_out++;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_steady > 0) begin
          out_steady--;
          out_gap = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) out_steady = $urandom_range(20, 80);
          out_gap = pick_gap();
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_BSL);
    return b;
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'(8'h30 + k);
    if (k < 16) return 8'(8'h41 + k - 10);
    return 8'(8'h61 + k - 16);
  endfunction

  task automatic put_escape();
    esc_kind_t kind;
    logic [7:0] b;
    kind = esc_kind_t'($urandom_range(0, 7));
    src_q.push_back(CH_BSL);
    case (kind)
      ESC_LF:  src_q.push_back(CH_N);
      ESC_TAB: src_q.push_back(CH_T);
      ESC_CR:  src_q.push_back(CH_R);
      ESC_BSL: src_q.push_back(CH_BSL);
      ESC_OTHER: begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_X);
        src_q.push_back(b);
      end
      ESC_HEX0: src_q.push_back(CH_X);
      ESC_HEX1: begin
        src_q.push_back(CH_X);
        src_q.push_back(hex_char());
      end
      default: begin
        src_q.push_back(CH_X);
        src_q.push_back(hex_char());
        src_q.push_back(hex_char());
      end
    endcase
  endtask

  task automatic put_string();
    int r;
    int len;
    int k;
    r = $urandom_range(0, 99);
    len = $urandom_range(0, 24);
    for (int i = 0; i < len; i++) begin
      if (r < 12) src_q.push_back(8'($urandom_range(1, 255)));
      else if ($urandom_range(0, 2) == 0) put_escape();
      else src_q.push_back(plain_char());
    end
    // unfinished escape right before the terminator
    if (r >= 88) begin
      k = $urandom_range(0, 2);
      src_q.push_back(CH_BSL);
      if (k >= 1) src_q.push_back(CH_X);
      if (k == 2) src_q.push_back(hex_char());
    end
    src_q.push_back(CH_NUL);
    n_strings++;
  endtask

  logic [7:0] dir_seq [35] = '{
    8'h41, 8'hFF, 8'h80, 8'h01,
    CH_BSL, CH_N, CH_BSL, CH_T, CH_BSL, CH_R, CH_BSL, CH_BSL, CH_BSL, 8'h71,
    CH_BSL, CH_X, 8'h66, 8'h46,
    CH_BSL, CH_X, 8'h67,
    CH_BSL, CH_X, 8'h37, CH_BSL, CH_N,
    CH_NUL,
    CH_BSL, CH_NUL,
    CH_BSL, CH_X, CH_NUL,
    CH_BSL, CH_X, 8'h61
  };

  int mark;

  initial begin
    foreach (dir_seq[i]) src_q.push_back(dir_seq[i]);
    src_q.push_back(CH_NUL);
    src_q.push_back(CH_NUL);
    n_strings += 5;

    mark = src_q.size();
    while (src_q.size() < mark + RAND_ITEMS / 2) put_string();

    // fill one string to the output limit, then keep feeding bytes that get dropped
    for (int i = 0; i < MAX_OUTPUT - 1; i++) src_q.push_back(plain_char());
    src_q.push_back(CH_BSL);
    src_q.push_back(CH_X);
    src_q.push_back(8'h34);
    src_q.push_back(8'h71);
    src_q.push_back(CH_BSL);
    src_q.push_back(CH_N);
    src_q.push_back(8'h41);
    src_q.push_back(CH_BSL);
    src_q.push_back(CH_X);
    src_q.push_back(CH_NUL);
    n_strings++;

    mark = src_q.size();
    while (src_q.size() < mark + RAND_ITEMS / 2) put_string();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
      #1;
    end while (src_q.size() != 0 || in_tvalid || decoded_q.size() != 0);
    repeat (20) @(posedge clk);
    #1;
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", decoded_q.size()));

    $display("decoded %0d strings from %0d source beats into %0d result beats",
             n_strings, n_in, n_out);
    $display("escapes, hex forms, cut-off escapes, output overflow and %0d long stall(s)",
             n_holds);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_err);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/esd_pkg.sv
rtl/esd_front.sv
rtl/esd_queue.sv
rtl/esd_back.sv
rtl/escape_sequence_decoder.sv
tb/tb_escape_sequence_decoder.sv
